[hdl/ln_pkg.sv]
`default_nettype none
package ln_pkg;

  // fixed field and datapath widths
  localparam int unsigned DataW   = 16;
  localparam int unsigned CntW    = 7;
  localparam int unsigned SumW    = 22;
  localparam int unsigned DiffW   = 24;
  localparam int unsigned SqW     = 48;
  localparam int unsigned AccW    = 53;
  localparam int unsigned DsrW    = 31;
  localparam int unsigned VarW    = 32;
  localparam int unsigned RootW   = 24;
  localparam int unsigned RootIn  = 48;
  localparam int unsigned NumW    = 40;
  localparam int unsigned FloorW  = 16;
  localparam int unsigned FloorReset = 1;
  localparam int unsigned RegFloor   = 0;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] gain;
    logic signed [DataW-1:0] offset;
    logic                    is_last;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] normalized;
    logic                    end_of_row;
    logic                    overflowed;
  } result_t;

  // one stored element
  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] gain;
    logic signed [DataW-1:0] offset;
  } entry_t;

  // closed row handed from front to back
  typedef struct packed {
    logic [CntW-1:0]        count;
    logic signed [SumW-1:0] sum;
    logic                   ovf;
  } row_t;

  typedef enum logic [4:0] {
    S_IDLE, S_P1_RD, S_P1_DIF, S_P1_MUL, S_P1_ACC, S_CUBE1, S_CUBE2,
    S_VDIV, S_VWAIT, S_SQ_RUN, S_DEN, S_P2_RD, S_P2_DIF, S_P2_MUL,
    S_P2_DIV, S_P2_WAIT, S_P2_SAT
  } back_state_e;

endpackage
`default_nettype wire

[hdl/ln_ram.sv]
`default_nettype none
module ln_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

[hdl/ln_front.sv]
`default_nettype none
module ln_front #(
  parameter int unsigned MAX_WIDTH = 64,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire ln_pkg::cmd_t    cmd_i,
  output logic                 wr_en_o,
  output logic [AW-1:0]        wr_addr_o,
  output ln_pkg::entry_t       wr_data_o,
  output logic                 push_o,
  output ln_pkg::row_t         row_o
);

  logic [CW-1:0]                   count_q, count_d;
  logic signed [ln_pkg::SumW-1:0]  sum_q, sum_d;
  logic                            ovf_q, ovf_d;
  logic                            room;

  // store while there is room, else flag the row
  always_comb begin
    room      = (count_q < CW'(MAX_WIDTH));
    wr_en_o   = accept_i && room;
    wr_addr_o = count_q[AW-1:0];
    wr_data_o = '{sample: cmd_i.sample, gain: cmd_i.gain, offset: cmd_i.offset};
    count_d   = count_q;
    sum_d     = sum_q;
    ovf_d     = ovf_q;
    if (accept_i) begin
      if (room) begin
        count_d = count_q + CW'(1);
        sum_d   = sum_q + ln_pkg::SumW'(cmd_i.sample);
      end else begin
        ovf_d = 1'b1;
      end
    end
    push_o      = accept_i && cmd_i.is_last;
    row_o.count = ln_pkg::CntW'(count_d);
    row_o.sum   = sum_d;
    row_o.ovf   = ovf_d;
  end

  // row counters, cleared when the row is handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (push_o) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule
`default_nettype wire

[hdl/ln_fifo.sv]
`default_nettype none
module ln_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire ln_pkg::row_t data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output ln_pkg::row_t      data_o
);

  ln_pkg::row_t buf_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = buf_q[rp_q];

  // two-entry row descriptor queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i && valid_o) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

[hdl/ln_div.sv]
`default_nettype none
module ln_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ln_pkg::AccW-1:0]   dividend_i,
  input  wire logic [ln_pkg::DsrW-1:0]   divisor_i,
  output logic                           done_o,
  output logic [ln_pkg::AccW-1:0]        quotient_o
);

  localparam int unsigned StepW = $clog2(ln_pkg::AccW);

  logic                       run_q;
  logic [StepW-1:0]           cnt_q;
  logic [ln_pkg::AccW-1:0]    dvd_q;
  logic [ln_pkg::DsrW-1:0]    rem_q, dsr_q;
  logic [ln_pkg::DsrW:0]      trial;
  logic                       ge;

  // one restoring step: shift in the next dividend bit
  always_comb begin
    trial = {rem_q, dvd_q[ln_pkg::AccW-1]};
    ge    = (trial >= {1'b0, dsr_q});
  end

  assign quotient_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + StepW'(1);
        if (cnt_q == StepW'(ln_pkg::AccW - 1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[ln_pkg::AccW-2:0], ge};
      rem_q <= ge ? ln_pkg::DsrW'(trial - {1'b0, dsr_q}) : ln_pkg::DsrW'(trial);
    end
  end

endmodule
`default_nettype wire

[hdl/ln_back.sv]
`default_nettype none
module ln_back #(
  parameter int unsigned MAX_WIDTH = 64,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       row_valid_i,
  input  wire ln_pkg::row_t               row_i,
  output logic                            pop_o,
  input  wire logic [ln_pkg::FloorW-1:0]  floor_i,
  output logic [AW-1:0]                   rd_addr_o,
  input  wire ln_pkg::entry_t             rd_data_i,
  output logic                            busy_o,
  output logic                            result_valid_o,
  output ln_pkg::result_t                 result_o
);

  localparam int unsigned SqStepW = $clog2(ln_pkg::RootIn / 2);
  localparam int unsigned TermW   = ln_pkg::AccW + 1;

  ln_pkg::back_state_e state_q, state_d;

  logic [ln_pkg::CntW-1:0]          n_q, idx_q;
  logic signed [ln_pkg::SumW-1:0]   sum_q;
  logic                             ovf_q, last_el;
  logic signed [ln_pkg::DiffW-1:0]  d_q, d_d;
  logic signed [ln_pkg::DataW-1:0]  g_q, o_q;
  logic [ln_pkg::SqW-1:0]           prod_q;
  logic [ln_pkg::AccW-1:0]          sumsq_q, quot_q;
  logic [2*ln_pkg::CntW-1:0]        n2_q;
  logic [3*ln_pkg::CntW-1:0]        n3_q;
  logic [ln_pkg::DsrW-1:0]          den_q;
  logic signed [ln_pkg::NumW-1:0]   num_q;
  logic [ln_pkg::NumW-1:0]          mag;
  logic [ln_pkg::VarW-1:0]          v_sum;
  logic signed [ln_pkg::CntW:0]     n_s;
  logic signed [ln_pkg::DiffW-1:0]  nx;

  logic [ln_pkg::RootIn-1:0]        sq_rem_q, sq_res_q, sq_bit_q, sq_sum;
  logic                             sq_ge;
  logic [SqStepW-1:0]               sq_cnt_q;

  logic                             div_start, div_done;
  logic [ln_pkg::AccW-1:0]          div_dvd, div_quot;
  logic [ln_pkg::DsrW-1:0]          div_dsr;

  logic signed [TermW-1:0]          term, rsum;
  logic signed [ln_pkg::DataW-1:0]  sat;

  // arithmetic shared by both passes
  always_comb begin
    n_s     = $signed({1'b0, n_q});
    nx      = n_s * rd_data_i.sample;
    d_d     = nx - ln_pkg::DiffW'(sum_q);
    last_el = (idx_q == n_q - ln_pkg::CntW'(1));
    v_sum   = ln_pkg::VarW'(div_quot) + ln_pkg::VarW'(floor_i);
    sq_sum  = sq_res_q + sq_bit_q;
    sq_ge   = (sq_rem_q >= sq_sum);
    mag     = num_q[ln_pkg::NumW-1] ? ln_pkg::NumW'(-num_q) : ln_pkg::NumW'(num_q);
    div_dvd = (state_q == ln_pkg::S_VDIV)
            ? sumsq_q
            : ln_pkg::AccW'({mag, 4'b0000}) + ln_pkg::AccW'(den_q >> 1);
    div_dsr = (state_q == ln_pkg::S_VDIV) ? ln_pkg::DsrW'(n3_q) : den_q;
    term    = num_q[ln_pkg::NumW-1] ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
    rsum    = term + TermW'(o_q);
    if (rsum > TermW'(signed'(ln_pkg::DataW'({1'b0, {(ln_pkg::DataW-1){1'b1}}})))) begin
      sat = {1'b0, {(ln_pkg::DataW-1){1'b1}}};
    end else if (rsum < -TermW'(signed'({1'b0, 1'b1, {(ln_pkg::DataW-1){1'b0}}}))) begin
      sat = {1'b1, {(ln_pkg::DataW-1){1'b0}}};
    end else begin
      sat = rsum[ln_pkg::DataW-1:0];
    end
  end

  assign rd_addr_o = idx_q[AW-1:0];
  assign busy_o    = (state_q != ln_pkg::S_IDLE);

  // sequencer: next state and control
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ln_pkg::S_IDLE: begin
        if (row_valid_i) begin
          pop_o   = 1'b1;
          state_d = ln_pkg::S_P1_RD;
        end
      end
      ln_pkg::S_P1_RD:  state_d = ln_pkg::S_P1_DIF;
      ln_pkg::S_P1_DIF: state_d = ln_pkg::S_P1_MUL;
      ln_pkg::S_P1_MUL: state_d = ln_pkg::S_P1_ACC;
      ln_pkg::S_P1_ACC: state_d = last_el ? ln_pkg::S_CUBE1 : ln_pkg::S_P1_RD;
      ln_pkg::S_CUBE1:  state_d = ln_pkg::S_CUBE2;
      ln_pkg::S_CUBE2:  state_d = ln_pkg::S_VDIV;
      ln_pkg::S_VDIV: begin
        div_start = 1'b1;
        state_d   = ln_pkg::S_VWAIT;
      end
      ln_pkg::S_VWAIT: begin
        if (div_done) begin
          state_d = ln_pkg::S_SQ_RUN;
        end
      end
      ln_pkg::S_SQ_RUN: begin
        if (sq_cnt_q == SqStepW'(ln_pkg::RootIn / 2 - 1)) begin
          state_d = ln_pkg::S_DEN;
        end
      end
      ln_pkg::S_DEN:    state_d = ln_pkg::S_P2_RD;
      ln_pkg::S_P2_RD:  state_d = ln_pkg::S_P2_DIF;
      ln_pkg::S_P2_DIF: state_d = ln_pkg::S_P2_MUL;
      ln_pkg::S_P2_MUL: state_d = ln_pkg::S_P2_DIV;
      ln_pkg::S_P2_DIV: begin
        if (den_q == '0) begin
          state_d = ln_pkg::S_P2_SAT;
        end else begin
          div_start = 1'b1;
          state_d   = ln_pkg::S_P2_WAIT;
        end
      end
      ln_pkg::S_P2_WAIT: begin
        if (div_done) begin
          state_d = ln_pkg::S_P2_SAT;
        end
      end
      ln_pkg::S_P2_SAT: state_d = last_el ? ln_pkg::S_IDLE : ln_pkg::S_P2_RD;
      default:          state_d = ln_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ln_pkg::S_IDLE;
      idx_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= (state_q == ln_pkg::S_P2_SAT);
      if (state_q == ln_pkg::S_IDLE) begin
        idx_q <= '0;
      end else if (state_q == ln_pkg::S_P1_ACC || state_q == ln_pkg::S_P2_SAT) begin
        idx_q <= last_el ? '0 : idx_q + ln_pkg::CntW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ln_pkg::S_IDLE: begin
        n_q     <= row_i.count;
        sum_q   <= row_i.sum;
        ovf_q   <= row_i.ovf;
        sumsq_q <= '0;
      end
      ln_pkg::S_P1_DIF: d_q <= d_d;
      ln_pkg::S_P1_MUL: prod_q <= ln_pkg::SqW'(d_q * d_q);
      ln_pkg::S_P1_ACC: sumsq_q <= sumsq_q + ln_pkg::AccW'(prod_q);
      ln_pkg::S_CUBE1:  n2_q <= n_q * n_q;
      ln_pkg::S_CUBE2:  n3_q <= n2_q * n_q;
      ln_pkg::S_VWAIT: begin
        sq_rem_q <= {v_sum, 16'h0000};
        sq_res_q <= '0;
        sq_bit_q <= ln_pkg::RootIn'(1) << (ln_pkg::RootIn - 2);
        sq_cnt_q <= '0;
      end
      ln_pkg::S_SQ_RUN: begin
        if (sq_ge) begin
          sq_rem_q <= sq_rem_q - sq_sum;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + SqStepW'(1);
      end
      ln_pkg::S_DEN: den_q <= ln_pkg::DsrW'(n_q * sq_res_q[ln_pkg::RootW-1:0]);
      ln_pkg::S_P2_DIF: begin
        d_q <= d_d;
        g_q <= rd_data_i.gain;
        o_q <= rd_data_i.offset;
      end
      ln_pkg::S_P2_MUL: num_q <= ln_pkg::NumW'(d_q * g_q);
      ln_pkg::S_P2_DIV: quot_q <= '0;
      ln_pkg::S_P2_WAIT: begin
        if (div_done) begin
          quot_q <= div_quot;
        end
      end
      ln_pkg::S_P2_SAT: begin
        result_o.normalized <= sat;
        result_o.end_of_row <= last_el;
        result_o.overflowed <= ovf_q;
      end
      default: ;
    endcase
  end

  // shared long divider for variance and per-element scaling
  ln_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

endmodule
`default_nettype wire

[hdl/layer_normalization.sv]
// Operation: a row of n stored elements is first read back for the sum of squares,
// then the variance divide and square root follow, then each element in turn is scaled
// (read, multiply, 53-step shared divider, saturate).
// Rows: one at a time, the next row is accepted only once the current one has finished;
// elements load at one per cycle while the block is free. Results cannot be stalled.
// Reset: asynchronous; clears counters, queue and sequencer; element stores are not cleared.
`default_nettype none
module layer_normalization #(
  parameter int unsigned MAX_WIDTH = 64,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire ln_pkg::cmd_t    cmd_i,
  output logic                 busy_o,
  output logic                 result_valid_o,
  output ln_pkg::result_t      result_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [ln_pkg::FloorW-1:0] floor_q;
  logic                      accept, wr_en, push, pop, row_valid, back_busy;
  logic [AW-1:0]             wr_addr, rd_addr;
  ln_pkg::entry_t            wr_data, rd_data;
  ln_pkg::row_t              row_in, row_out;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'(ln_pkg::RegFloor)) ? 32'(floor_q) : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= ln_pkg::FloorW'(ln_pkg::FloorReset);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'(ln_pkg::RegFloor)) begin
      floor_q <= pwdata[ln_pkg::FloorW-1:0];
    end
  end

  // input transfer
  assign busy_o = row_valid || back_busy;
  assign accept = start_i && !busy_o;

  ln_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .row_o     (row_in)
  );

  ln_ram #(.WIDTH($bits(ln_pkg::entry_t)), .DEPTH(MAX_WIDTH)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ln_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (row_in),
    .pop_i   (pop),
    .valid_o (row_valid),
    .data_o  (row_out)
  );

  ln_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_valid_i    (row_valid),
    .row_i          (row_out),
    .pop_o          (pop),
    .floor_i        (floor_q),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .busy_o         (back_busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // a closed row blocks the input until it is processed
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.is_last) |=> busy_o)
    else $error("input not blocked after row end");

  // the row end result is followed by a quiet cycle
  a_row_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.end_of_row) |=> !result_valid_o)
    else $error("result straight after row end");

  // the back end is idle whenever the front accepts an element into the store
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !back_busy)
    else $error("store written while rows are processed");

endmodule
`default_nettype wire
